// File: hdl/fpfa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpfa_pkg
// Shared codes and types of the fixed partition fit allocator.
// ----------------------------------------------------------------------------
package fpfa_pkg;

	localparam int MAX_PARTITIONS_DEF = 16;
	localparam int SIZE_BITS_DEF      = 16;

	localparam int CMD_W   = 2;
	localparam int PIDX_W  = 4;
	localparam int VAL_W   = 16;
	localparam int STAT_W  = 2;
	localparam int OUT_W   = 20;
	localparam int PCNT_W  = 5;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 5;
	localparam logic [OUT_W-1:0] OUT_MAX = 20'hFFFFF;

	localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

	localparam logic [STAT_W-1:0] STAT_GRANT  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOFIT  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_DONE   = 2'd2;

	localparam logic [1:0] MODE_FIRST = 2'd0;
	localparam logic [1:0] MODE_BEST  = 2'd1;
	localparam logic [1:0] MODE_WORST = 2'd2;
	localparam logic [1:0] MODE_NEXT  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT = 8'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_LAUNCH,
		ST_WAIT,
		ST_DONE
	} state_t;

	// table updates broadcast to every cell
	typedef struct packed {
		logic load;
		logic clear;
		logic mark;
	} cell_ctl_t;

endpackage
`default_nettype wire

// File: hdl/fixed_partition_fit_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_core
// Partition table kept in a chain of cells; every word sends one search word
// down the chain and returns one result word.
// Each word first reduces the next-fit start position modulo the count, then
//   walks the chain of MAX_PARTITIONS cells and is delivered to the output
//   register. One word is in flight at a time: the next word is accepted only
//   once the previous result has moved into the output register.
//   A waiting result does not block the next accept.
// Reset: arst_n clears the table to zero sizes, no marks, zero totals,
//   fit_mode 0 and partition_count 16.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator_core #(
	parameter int MAX_PARTITIONS = fpfa_pkg::MAX_PARTITIONS_DEF,
	parameter int SIZE_BITS      = fpfa_pkg::SIZE_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	// tdata: command[1:0], partition_index[5:2], size_value[21:6], zero pad
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [23:0] s_axis_tdata,
	// tdata: status[1:0], granted_index[5:2], fragmentation[21:6],
	//        frag_total[41:22], remaining_free[61:42], zero pad
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [63:0] m_axis_tdata,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [fpfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [fpfa_pkg::CFG_DAT_W-1:0] cfg_data
);

	localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
	localparam int NUM_W = $clog2(MAX_PARTITIONS + 1);
	localparam int SUM_W = (SIZE_BITS + IDX_W + 1 > 21) ? SIZE_BITS + IDX_W + 1 : 21;
	localparam int TOT_W = (SIZE_BITS > 20) ? SIZE_BITS + 1 : 21;
	localparam int OW    = fpfa_pkg::OUT_W;

	// configuration registers
	logic [1:0]                  fit_mode_q;
	logic [fpfa_pkg::PCNT_W-1:0] pcount_q;

	// item under work
	fpfa_pkg::state_t             state_q, state_d;
	logic [fpfa_pkg::CMD_W-1:0]   cmd_q;
	logic [SIZE_BITS-1:0]         want_q;
	logic [IDX_W-1:0]             last_q;
	logic [IDX_W-1:0]             rem_q;
	logic [OW-1:0]                total_q;

	// chain result held until the output register is free
	logic                         found_q;
	logic [IDX_W-1:0]             pick_idx_q;
	logic [SIZE_BITS-1:0]         pick_size_q;
	logic [SUM_W-1:0]             sum_q;

	logic                         accept;
	logic                         finish;
	logic                         granted;
	logic [NUM_W-1:0]             count;
	logic [fpfa_pkg::CMD_W-1:0]   in_cmd;
	logic [fpfa_pkg::PIDX_W-1:0]  in_idx;
	logic [SIZE_BITS+15:0]        in_wide;
	logic [SIZE_BITS-1:0]         in_size;
	fpfa_pkg::cell_ctl_t          ctl;

	logic [SIZE_BITS-1:0]         frag;
	logic [SIZE_BITS+15:0]        frag_wide;
	logic [IDX_W+3:0]             gidx_wide;
	logic [TOT_W-1:0]             tot_sum;
	logic [OW-1:0]                total_d;
	logic [SUM_W-1:0]             free_sum;
	logic [OW-1:0]                free_out;
	logic [fpfa_pkg::STAT_W-1:0]  status;

	// chain taps, entry 0 fed by the launcher
	logic                 tk_valid    [MAX_PARTITIONS+1];
	logic                 tk_hi_found [MAX_PARTITIONS+1];
	logic [IDX_W-1:0]     tk_hi_idx   [MAX_PARTITIONS+1];
	logic [SIZE_BITS-1:0] tk_hi_size  [MAX_PARTITIONS+1];
	logic                 tk_lo_found [MAX_PARTITIONS+1];
	logic [IDX_W-1:0]     tk_lo_idx   [MAX_PARTITIONS+1];
	logic [SIZE_BITS-1:0] tk_lo_size  [MAX_PARTITIONS+1];
	logic [SUM_W-1:0]     tk_sum      [MAX_PARTITIONS+1];

	assign in_cmd  = s_axis_tdata[1:0];
	assign in_idx  = s_axis_tdata[5:2];
	assign in_wide = (SIZE_BITS + 16)'(s_axis_tdata[21:6]);
	assign in_size = in_wide[SIZE_BITS-1:0];

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == fpfa_pkg::ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign finish        = (state_q == fpfa_pkg::ST_DONE) && (!m_axis_tvalid || m_axis_tready);
	assign granted       = (cmd_q == fpfa_pkg::CMD_REQUEST) && found_q;

	// clamp the partition count to the table depth
	assign count = (32'(pcount_q) > MAX_PARTITIONS) ? NUM_W'(MAX_PARTITIONS)
	                                                : NUM_W'(pcount_q);

	always_comb begin
		ctl.load  = accept && (in_cmd == fpfa_pkg::CMD_LOAD);
		ctl.clear = accept && (in_cmd == fpfa_pkg::CMD_CLEAR);
		ctl.mark  = finish && granted;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= fpfa_pkg::MODE_FIRST;
			pcount_q   <= fpfa_pkg::PCNT_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == fpfa_pkg::CFG_FIT_MODE)
				fit_mode_q <= cfg_data[1:0];
			else if (cfg_index == fpfa_pkg::CFG_PART_COUNT)
				pcount_q <= cfg_data;
		end
	end

	// sequencer: reduce the start position, launch, wait for the chain, deliver
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fpfa_pkg::ST_IDLE:
				if (accept)
					state_d = fpfa_pkg::ST_MOD;
			fpfa_pkg::ST_MOD:
				if (count == '0 || 32'(rem_q) < 32'(count))
					state_d = fpfa_pkg::ST_LAUNCH;
			fpfa_pkg::ST_LAUNCH:
				state_d = fpfa_pkg::ST_WAIT;
			fpfa_pkg::ST_WAIT:
				if (tk_valid[MAX_PARTITIONS])
					state_d = fpfa_pkg::ST_DONE;
			fpfa_pkg::ST_DONE:
				if (finish)
					state_d = fpfa_pkg::ST_IDLE;
			default:
				state_d = fpfa_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= fpfa_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// latch the word, reduce the start position modulo the count by repeated subtraction, capture the chain result
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= in_cmd;
			want_q <= in_size;
			rem_q  <= (in_cmd == fpfa_pkg::CMD_CLEAR) ? '0 : last_q;
		end else if (state_q == fpfa_pkg::ST_MOD && count != '0
		             && 32'(rem_q) >= 32'(count)) begin
			rem_q <= rem_q - IDX_W'(count);
		end
		if (state_q == fpfa_pkg::ST_WAIT && tk_valid[MAX_PARTITIONS]) begin
			found_q     <= tk_hi_found[MAX_PARTITIONS] || tk_lo_found[MAX_PARTITIONS];
			pick_idx_q  <= tk_hi_found[MAX_PARTITIONS] ? tk_hi_idx[MAX_PARTITIONS]
			                                           : tk_lo_idx[MAX_PARTITIONS];
			pick_size_q <= tk_hi_found[MAX_PARTITIONS] ? tk_hi_size[MAX_PARTITIONS]
			                                           : tk_lo_size[MAX_PARTITIONS];
			sum_q       <= tk_sum[MAX_PARTITIONS];
		end
	end

	// launch an empty search word into the chain
	assign tk_valid[0]    = (state_q == fpfa_pkg::ST_LAUNCH);
	assign tk_hi_found[0] = 1'b0;
	assign tk_hi_idx[0]   = '0;
	assign tk_hi_size[0]  = '0;
	assign tk_lo_found[0] = 1'b0;
	assign tk_lo_idx[0]   = '0;
	assign tk_lo_size[0]  = '0;
	assign tk_sum[0]      = '0;

	for (genvar g = 0; g < MAX_PARTITIONS; g++) begin : g_cell
		fpfa_cell #(
			.INDEX     (g),
			.SIZE_BITS (SIZE_BITS),
			.IDX_W     (IDX_W),
			.NUM_W     (NUM_W),
			.SUM_W     (SUM_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.load_index  (in_idx),
			.load_size   (in_size),
			.mark_index  (pick_idx_q),
			.mode        (fit_mode_q),
			.want        (want_q),
			.start       (rem_q),
			.count       (count),
			.up_valid    (tk_valid[g]),
			.up_hi_found (tk_hi_found[g]),
			.up_hi_idx   (tk_hi_idx[g]),
			.up_hi_size  (tk_hi_size[g]),
			.up_lo_found (tk_lo_found[g]),
			.up_lo_idx   (tk_lo_idx[g]),
			.up_lo_size  (tk_lo_size[g]),
			.up_sum      (tk_sum[g]),
			.dn_valid    (tk_valid[g+1]),
			.dn_hi_found (tk_hi_found[g+1]),
			.dn_hi_idx   (tk_hi_idx[g+1]),
			.dn_hi_size  (tk_hi_size[g+1]),
			.dn_lo_found (tk_lo_found[g+1]),
			.dn_lo_idx   (tk_lo_idx[g+1]),
			.dn_lo_size  (tk_lo_size[g+1]),
			.dn_sum      (tk_sum[g+1])
		);
	end

	// result arithmetic: drop the granted size from the free sum, saturate totals
	always_comb begin
		frag      = granted ? (pick_size_q - want_q) : '0;
		frag_wide = (SIZE_BITS + 16)'(frag);
		gidx_wide = granted ? (IDX_W + 4)'(pick_idx_q) : '0;
		tot_sum   = TOT_W'(total_q) + TOT_W'(frag);
		total_d   = (tot_sum > TOT_W'(fpfa_pkg::OUT_MAX)) ? fpfa_pkg::OUT_MAX
		                                                  : OW'(tot_sum);
		free_sum  = sum_q - (granted ? SUM_W'(pick_size_q) : '0);
		free_out  = (free_sum > SUM_W'(fpfa_pkg::OUT_MAX)) ? fpfa_pkg::OUT_MAX
		                                                   : OW'(free_sum);
		if (granted)
			status = fpfa_pkg::STAT_GRANT;
		else if (cmd_q == fpfa_pkg::CMD_LOAD || cmd_q == fpfa_pkg::CMD_CLEAR)
			status = fpfa_pkg::STAT_DONE;
		else
			status = fpfa_pkg::STAT_NOFIT;
	end

	// running totals and next-fit position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			total_q <= '0;
		end else if (ctl.clear) begin
			last_q  <= '0;
			total_q <= '0;
		end else if (finish && granted) begin
			last_q  <= pick_idx_q;
			total_q <= total_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tvalid <= 1'b0;
		else if (finish)
			m_axis_tvalid <= 1'b1;
		else if (m_axis_tready)
			m_axis_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (finish)
			m_axis_tdata <= {2'b00, free_out, (granted ? total_d : total_q),
			                 frag_wide[15:0], gidx_wide[3:0], status};
	end

endmodule
`default_nettype wire

// File: hdl/fpfa_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpfa_cell
// One partition entry: holds size and mark, folds itself into the search
// word passing down the chain and registers it for the next cell.
// ----------------------------------------------------------------------------
module fpfa_cell #(
	parameter int INDEX     = 0,
	parameter int SIZE_BITS = 16,
	parameter int IDX_W     = 4,
	parameter int NUM_W     = 5,
	parameter int SUM_W     = 21
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire fpfa_pkg::cell_ctl_t         ctl,
	input  wire  [fpfa_pkg::PIDX_W-1:0]      load_index,
	input  wire  [SIZE_BITS-1:0]             load_size,
	input  wire  [IDX_W-1:0]                 mark_index,
	input  wire  [1:0]                       mode,
	input  wire  [SIZE_BITS-1:0]             want,
	input  wire  [IDX_W-1:0]                 start,
	input  wire  [NUM_W-1:0]                 count,
	input  wire                              up_valid,
	input  wire                              up_hi_found,
	input  wire  [IDX_W-1:0]                 up_hi_idx,
	input  wire  [SIZE_BITS-1:0]             up_hi_size,
	input  wire                              up_lo_found,
	input  wire  [IDX_W-1:0]                 up_lo_idx,
	input  wire  [SIZE_BITS-1:0]             up_lo_size,
	input  wire  [SUM_W-1:0]                 up_sum,
	output logic                             dn_valid,
	output logic                             dn_hi_found,
	output logic [IDX_W-1:0]                 dn_hi_idx,
	output logic [SIZE_BITS-1:0]             dn_hi_size,
	output logic                             dn_lo_found,
	output logic [IDX_W-1:0]                 dn_lo_idx,
	output logic [SIZE_BITS-1:0]             dn_lo_size,
	output logic [SUM_W-1:0]                 dn_sum
);

	logic [SIZE_BITS-1:0] size_q;
	logic                 mark_q;
	logic                 active;
	logic                 fits;
	logic                 in_hi;
	logic                 take_hi;
	logic                 take_lo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
			mark_q <= 1'b0;
		end else begin
			if (ctl.clear)
				mark_q <= 1'b0;
			if (ctl.load && (32'(load_index) == INDEX)) begin
				size_q <= load_size;
				mark_q <= 1'b0;
			end
			if (ctl.mark && (32'(mark_index) == INDEX))
				mark_q <= 1'b1;
		end
	end

	always_comb begin
		active  = 32'(count) > INDEX;
		fits    = active && !mark_q && (size_q >= want);
		in_hi   = (mode != fpfa_pkg::MODE_NEXT) || (INDEX >= 32'(start));
		take_lo = 1'b0;
		unique case (mode)
			fpfa_pkg::MODE_BEST:
				take_hi = fits && (!up_hi_found || size_q < up_hi_size);
			fpfa_pkg::MODE_WORST:
				take_hi = fits && (!up_hi_found || size_q > up_hi_size);
			fpfa_pkg::MODE_FIRST:
				take_hi = fits && !up_hi_found;
			default: begin
				take_hi = fits && in_hi && !up_hi_found;
				take_lo = fits && !in_hi && !up_lo_found;
			end
		endcase
	end

	// advance the search word one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dn_valid <= 1'b0;
		else
			dn_valid <= up_valid;
	end

	always_ff @(posedge clk) begin
		dn_hi_found <= up_hi_found || take_hi;
		dn_hi_idx   <= take_hi ? IDX_W'(INDEX) : up_hi_idx;
		dn_hi_size  <= take_hi ? size_q : up_hi_size;
		dn_lo_found <= up_lo_found || take_lo;
		dn_lo_idx   <= take_lo ? IDX_W'(INDEX) : up_lo_idx;
		dn_lo_size  <= take_lo ? size_q : up_lo_size;
		dn_sum      <= up_sum + ((active && !mark_q) ? SUM_W'(size_q) : '0);
	end

endmodule
`default_nettype wire

// File: sim/tb_fixed_partition_fit_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_partition_fit_allocator_core
// Streams load, request and clear words through the allocator under changing
// fit modes and partition counts, with random gaps and stalls on both sides,
// and checks every result word against a local model of the partition table.
// ----------------------------------------------------------------------------
module tb_fixed_partition_fit_allocator_core;

	localparam int NPART      = 16;
	localparam int SETTLE_CYC = 60;     // chain latency plus next-fit reduction
	localparam int HOLD_CYC   = 400;    // long receiver hold-off

	localparam logic [fpfa_pkg::CMD_W-1:0]     CMD_UNDEF   = 2'd3;
	localparam logic [fpfa_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 8'd7;

	typedef struct packed {
		logic [fpfa_pkg::STAT_W-1:0] status;
		logic [3:0]                  gidx;
		logic [15:0]                 frag;
		logic [fpfa_pkg::OUT_W-1:0]  total;
		logic [fpfa_pkg::OUT_W-1:0]  free;
	} alloc_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [fpfa_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [fpfa_pkg::CFG_DAT_W-1:0] cfg_data;

	fixed_partition_fit_allocator_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Local copy of the partition table and configuration
	logic [15:0] part_size [NPART];
	bit          part_mark [NPART];
	int unsigned grant_pos;
	int unsigned frag_sum;
	logic [1:0]  mode_cur;
	int unsigned count_cur;

	logic [23:0]   pending_words[$];
	alloc_result_t awaited_results[$];

	int  send_idle_pct;
	int  recv_stall_pct;
	int  hold_left;
	bit  in_fired;
	int  errors;
	int  n_checked;
	int  n_grants;
	int  n_nofit;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("timeout at %0t", $time);
		$display("** fixed_partition_fit_allocator_core: FAILED **");
		$finish;
	end

	function automatic logic [23:0] pack_word(logic [1:0] cmd, logic [3:0] idx,
			logic [15:0] val);
		return {2'b00, val, idx, cmd};
	endfunction

	// Apply one input word to the table and return the result it must produce
	function automatic alloc_result_t table_step(logic [23:0] w);
		logic [1:0]    cmd;
		logic [3:0]    idx;
		logic [15:0]   val;
		alloc_result_t r;
		int            n;
		int            pick;
		int            k;
		int unsigned   free_acc;
		cmd  = w[1:0];
		idx  = w[5:2];
		val  = w[21:6];
		r    = '0;
		r.status = fpfa_pkg::STAT_NOFIT;
		n    = (count_cur > NPART) ? NPART : int'(count_cur);
		pick = -1;
		if (cmd == fpfa_pkg::CMD_LOAD) begin
			part_size[idx] = val;
			part_mark[idx] = 1'b0;
			r.status = fpfa_pkg::STAT_DONE;
		end else if (cmd == fpfa_pkg::CMD_CLEAR) begin
			foreach (part_mark[i]) part_mark[i] = 1'b0;
			frag_sum  = 0;
			grant_pos = 0;
			r.status  = fpfa_pkg::STAT_DONE;
		end else if (cmd == fpfa_pkg::CMD_REQUEST && n > 0) begin
			if (mode_cur == fpfa_pkg::MODE_NEXT) begin
				for (int i = 0; i < n; i++) begin
					k = (grant_pos % n + i) % n;
					if (pick < 0 && !part_mark[k] && part_size[k] >= val) pick = k;
				end
			end else begin
				for (int i = 0; i < n; i++) begin
					if (part_mark[i] || part_size[i] < val) continue;
					if (pick < 0 ||
							(mode_cur == fpfa_pkg::MODE_BEST &&
							 part_size[i] < part_size[pick]) ||
							(mode_cur == fpfa_pkg::MODE_WORST &&
							 part_size[i] > part_size[pick]))
						if (!(mode_cur == fpfa_pkg::MODE_FIRST && pick >= 0)) pick = i;
				end
			end
			if (pick >= 0) begin
				part_mark[pick] = 1'b1;
				grant_pos = pick;
				r.status  = fpfa_pkg::STAT_GRANT;
				r.gidx    = 4'(pick);
				r.frag    = part_size[pick] - val;
				frag_sum  = frag_sum + r.frag;
				if (frag_sum > fpfa_pkg::OUT_MAX) frag_sum = fpfa_pkg::OUT_MAX;
			end
		end
		free_acc = 0;
		for (int i = 0; i < n; i++)
			if (!part_mark[i]) free_acc += part_size[i];
		r.total = fpfa_pkg::OUT_W'(frag_sum);
		r.free  = (free_acc > fpfa_pkg::OUT_MAX) ? fpfa_pkg::OUT_MAX
		                                         : fpfa_pkg::OUT_W'(free_acc);
		return r;
	endfunction

	// Sender: advance to the next word once the current one is taken
	always @(negedge clk) begin
		if (!s_axis_tvalid || in_fired) begin
			if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= pending_words.pop_front();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: hold off for a counted stretch, otherwise stall at random
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Predict on every accepted input word
	always @(posedge clk) begin
		in_fired = s_axis_tvalid && s_axis_tready;
		if (in_fired) awaited_results.push_back(table_step(s_axis_tdata));
	end

	// Check every accepted result word against the oldest prediction
	always @(posedge clk) begin
		alloc_result_t got;
		alloc_result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[1:0], m_axis_tdata[5:2], m_axis_tdata[21:6],
				m_axis_tdata[41:22], m_axis_tdata[61:42]};
			if (awaited_results.size() == 0) begin
				errors++;
				$display("%0t unexpected result word %h", $time, m_axis_tdata);
			end else begin
				want = awaited_results.pop_front();
				n_checked++;
				if (want.status == fpfa_pkg::STAT_GRANT) n_grants++;
				if (want.status == fpfa_pkg::STAT_NOFIT) n_nofit++;
				if (got !== want) begin
					errors++;
					$display("%0t mismatch: expected st=%0d idx=%0d frag=%0d tot=%0d free=%0d",
						$time, want.status, want.gidx, want.frag, want.total, want.free);
					$display("%0t            actual st=%0d idx=%0d frag=%0d tot=%0d free=%0d",
						$time, got.status, got.gidx, got.frag, got.total, got.free);
				end
			end
		end
	end

	task automatic write_reg(logic [fpfa_pkg::CFG_IDX_W-1:0] idx,
			logic [fpfa_pkg::CFG_DAT_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == fpfa_pkg::CFG_FIT_MODE) mode_cur = val[1:0];
		else if (idx == fpfa_pkg::CFG_PART_COUNT) count_cur = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Wait until every word is sent and answered, then let the chain settle
	task automatic drain();
		int guard;
		guard = 0;
		while ((pending_words.size() != 0 || s_axis_tvalid ||
				awaited_results.size() != 0) && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic queue_random(bit heavy);
		int          r;
		logic [1:0]  cmd;
		logic [15:0] val;
		r = $urandom_range(0, 99);
		if (r < 30) cmd = fpfa_pkg::CMD_LOAD;
		else if (r < 90) cmd = fpfa_pkg::CMD_REQUEST;
		else if (r < 96) cmd = heavy ? fpfa_pkg::CMD_REQUEST : fpfa_pkg::CMD_CLEAR;
		else cmd = CMD_UNDEF;
		if (heavy) val = (cmd == fpfa_pkg::CMD_LOAD) ? 16'hFFFF : 16'd0;
		else if ($urandom_range(0, 99) < 80) val = 16'($urandom_range(0, 64));
		else val = 16'($urandom);
		pending_words.push_back(pack_word(cmd, 4'($urandom_range(0, 15)), val));
	endtask

	initial begin
		int part_counts [14];
		part_counts   = '{16, 1, 0, 5, 31, 17, 16, 9, 16, 3, 12, 16, 2, 16};
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left     = 0;
		in_fired      = 1'b0;
		errors = 0; n_checked = 0; n_grants = 0; n_nofit = 0;
		foreach (part_size[i]) begin
			part_size[i] = '0;
			part_mark[i] = 1'b0;
		end
		grant_pos = 0; frag_sum = 0;
		mode_cur  = fpfa_pkg::MODE_FIRST;
		count_cur = 16;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: fill the table with edge sizes, then hit each corner
		for (int i = 0; i < NPART; i++)
			pending_words.push_back(pack_word(fpfa_pkg::CMD_LOAD, 4'(i),
				(i == 0) ? 16'd0 : (i == 15) ? 16'hFFFF : 16'(i * 100)));
		// zero-size takes size 0
		pending_words.push_back(pack_word(fpfa_pkg::CMD_REQUEST, 4'hF, 16'd0));
		// only the largest fits
		pending_words.push_back(pack_word(fpfa_pkg::CMD_REQUEST, 4'h0, 16'hFFFF));
		// nothing fits now
		pending_words.push_back(pack_word(fpfa_pkg::CMD_REQUEST, 4'h0, 16'hFFFF));
		// undefined command
		pending_words.push_back(pack_word(CMD_UNDEF, 4'hF, 16'hFFFF));
		pending_words.push_back(pack_word(fpfa_pkg::CMD_REQUEST, 4'h0, 16'd250));
		pending_words.push_back(pack_word(fpfa_pkg::CMD_CLEAR, 4'h0, 16'd0));
		pending_words.push_back(pack_word(fpfa_pkg::CMD_REQUEST, 4'h0, 16'd1));
		pending_words.push_back(pack_word(fpfa_pkg::CMD_LOAD, 4'hA, 16'hAAAA));
		drain();
		write_reg(CFG_UNMAPPED, 5'h1F);   // unmapped index, must be ignored

		for (int p = 0; p < 14; p++) begin
			write_reg(fpfa_pkg::CFG_FIT_MODE, {3'($urandom_range(0, 7)), 2'(p % 4)});
			write_reg(fpfa_pkg::CFG_PART_COUNT, fpfa_pkg::CFG_DAT_W'(part_counts[p]));
			case ((p / 2) % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
				default: begin send_idle_pct = 8; recv_stall_pct = 8; end
			endcase
			if (p == 8) begin
				// back up the allocator and stall its input behind a held-off receiver
				send_idle_pct  = 0;
				recv_stall_pct = 0;
				hold_left      = HOLD_CYC;
			end
			for (int i = 0; i < 125; i++) begin
				queue_random(p == 6);
				if (p == 10 && i % 25 == 24) drain();
			end
			drain();
		end

		$display("checked %0d result words: %0d grants, %0d no-fit, errors %0d",
			n_checked, n_grants, n_nofit, errors);
		$display("covered all fit modes, counts 0 to 31, saturation, stalls and gaps");
		if (errors == 0 && awaited_results.size() == 0)
			$display("** fixed_partition_fit_allocator_core: PASSED **");
		else
			$display("** fixed_partition_fit_allocator_core: FAILED **");
		$finish;
	end

endmodule
